// ----- sv/mexp_pkg.sv -----
// package for the modular exponentiation unit: widths, states and multiplier types
`timescale 1ns / 1ps

package mexp_pkg;

	// width of the ports and configuration words
	localparam int FIELD_BITS = 32;
	// bits of base, exponent and modulus that take part in the arithmetic
	localparam int WORD_BITS = 32;
	// bit counter of the shared multiplier
	localparam int IDX_BITS = $clog2(WORD_BITS);
	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(WORD_BITS - 1);

	// configuration register indexes
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR
	} state_t;

	// request to the shared modular multiplier
	typedef struct packed {
		logic go;
		logic [WORD_BITS-1:0] scan_op;
		logic [WORD_BITS-1:0] add_op;
		logic [WORD_BITS:0] modv;
	} mm_req_t;

	// response of the shared modular multiplier
	typedef struct packed {
		logic done;
		logic [WORD_BITS-1:0] result;
	} mm_rsp_t;

endpackage

// ----- sv/mexp_mulmod.sv -----
// bit-serial interleaved modular multiplier, one scan bit per cycle
`timescale 1ns / 1ps

module mexp_mulmod (
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_pkg::mm_req_t req,
	output mexp_pkg::mm_rsp_t rsp
);
	import mexp_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [IDX_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] scan_q;
	logic [WORD_BITS-1:0] add_q;
	logic [WORD_BITS:0]   mod_q;

	logic [WORD_BITS+1:0] t_sum;
	logic [WORD_BITS+1:0] m1;
	logic [WORD_BITS+1:0] m2;
	logic [WORD_BITS+1:0] t_red;

	// double, add the addend on a set scan bit, then fold back below the modulus
	always_comb begin
		m1 = {1'b0, mod_q};
		m2 = {mod_q, 1'b0};
		t_sum = {1'b0, r_q, 1'b0} +
			(scan_q[WORD_BITS-1] ? {2'b00, add_q} : '0);
		if (t_sum >= m2) begin
			t_red = t_sum - m2;
		end else if (t_sum >= m1) begin
			t_red = t_sum - m1;
		end else begin
			t_red = t_sum;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IDX_LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (req.go) begin
			r_q <= '0;
			scan_q <= req.scan_op;
			add_q <= req.add_op;
			mod_q <= req.modv;
		end else if (run_q) begin
			r_q <= t_red[WORD_BITS-1:0];
			scan_q <= {scan_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = r_q;

endmodule

// ----- sv/modular_exponentiation_unit.sv -----
// modular exponentiation top level: config registers, square-and-multiply sequencer
//
// channel   signals                       handshake
// config    wr_en, wr_index, wr_data      write when wr_en high, no wait
// input     start, base                   beat taken when start high and busy low
// output    done, power_mod               one-cycle strobe, cannot be held off
//
// one shared bit-serial modular multiplier does every product
// an item takes one base reduction, one product per set exponent bit and one square per
// exponent bit below the top set one; a zero exponent needs no product
// busy stays high from the accepted beat until the done strobe
// reset clears the sequencer and sets exponent 0, modulus 1
`timescale 1ns / 1ps

module modular_exponentiation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [mexp_pkg::FIELD_BITS-1:0] wr_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [mexp_pkg::FIELD_BITS-1:0] base,
	output logic                          done,
	output logic [mexp_pkg::FIELD_BITS-1:0] power_mod
);
	import mexp_pkg::*;

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] exponent_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS:0]   m_q;
	logic                 done_q;
	logic [FIELD_BITS-1:0] power_mod_q;

	logic [WORD_BITS:0]   m_new;
	logic [WORD_BITS-1:0] one_red;
	logic                 finish;
	mm_req_t              req;
	mm_rsp_t              rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q <= WORD_BITS'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXPONENT: exponent_q <= wr_data[WORD_BITS-1:0];
				REG_MODULUS:  modulus_q <= wr_data[WORD_BITS-1:0];
				default:      ;
			endcase
		end
	end

	// a zero modulus stands for 2^WORD_BITS; one reduced by the modulus for base reduction
	always_comb begin
		m_new = (modulus_q == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_q};
		one_red = (m_new == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);
	end

	assign finish = (state_q == ST_STEP) && (e_q == '0);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier requests
	always_comb begin
		state_d = state_q;
		req.go = 1'b0;
		req.scan_op = acc_q;
		req.add_op = a_q;
		req.modv = m_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (exponent_q == '0) begin
						state_d = ST_STEP;
					end else begin
						req.go = 1'b1;
						req.scan_op = base[WORD_BITS-1:0];
						req.add_op = one_red;
						req.modv = m_new;
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (rsp.done) state_d = ST_STEP;
			end
			ST_STEP: begin
				if (e_q == '0) begin
					state_d = ST_IDLE;
				end else if (e_q[0]) begin
					req.go = 1'b1;
					state_d = ST_MUL;
				end else begin
					req.go = 1'b1;
					req.scan_op = a_q;
					state_d = ST_SQR;
				end
			end
			ST_MUL: begin
				if (rsp.done) state_d = ST_STEP;
			end
			ST_SQR: begin
				if (rsp.done) state_d = ST_STEP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// working values: base power, remaining exponent, accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			a_q <= base[WORD_BITS-1:0];
			e_q <= exponent_q;
			acc_q <= WORD_BITS'(1);
			m_q <= m_new;
		end else if (rsp.done) begin
			if (state_q == ST_REDUCE) begin
				a_q <= rsp.result;
			end else if (state_q == ST_MUL) begin
				acc_q <= rsp.result;
				e_q[0] <= 1'b0;
			end else if (state_q == ST_SQR) begin
				a_q <= rsp.result;
				e_q <= {1'b0, e_q[WORD_BITS-1:1]};
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (finish) power_mod_q <= FIELD_BITS'(acc_q);
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign power_mod = power_mod_q;

endmodule

// ----- sv/mexp_checker.sv -----
// port-level checks for the modular exponentiation unit and their bind
`timescale 1ns / 1ps

module mexp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import mexp_pkg::*;

	// a result beat comes only once the unit is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	// an accepted beat makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	// busy drops only with a result
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
